// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, ignored while reset is asserted
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, ignored while reset is asserted
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication in the next cycle, checked through reset
`define QTE_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qte_pkg.sv =====
package qte_pkg;

    localparam int COMPONENT_WIDTH     = 16;
    localparam int CORDIC_STAGES       = 16;
    localparam int TABLE_LEN           = 24;
    localparam int THRESH_W            = 29;
    localparam int CW                  = 34;
    localparam int SQRT_W              = 58;
    localparam int SQRT_CELLS          = 29;
    localparam logic [THRESH_W-1:0] THRESH_RST = 29'd1;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] quat_w;
        logic signed [COMPONENT_WIDTH-1:0] quat_x;
        logic signed [COMPONENT_WIDTH-1:0] quat_y;
        logic signed [COMPONENT_WIDTH-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               gimbal_singular;
    } t_euler;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r10;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] nr12;
        logic signed [31:0] r11;
        logic signed [29:0] s;
        logic [61:0]        sq00;
        logic [61:0]        sq10;
        logic [57:0]        ss;
    } t_mat;

    typedef struct packed {
        logic [SQRT_W-1:0] n;
        logic [SQRT_W-1:0] r;
    } t_sq;

    typedef struct packed {
        logic signed [CW-1:0] roll_x;
        logic signed [CW-1:0] roll_y;
        logic signed [CW-1:0] yaw_x;
        logic signed [CW-1:0] yaw_y;
        logic signed [29:0]   s;
        logic                 sing;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          acc;
        logic                 zero;
    } t_cordic;

    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] v;
        v = 32'd0;
        unique case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat30(input logic signed [34:0] v);
        logic signed [31:0] o;
        if (v > 35'sd1073741824) begin
            o = 32'sd1073741824;
        end else if (v < -35'sd1073741824) begin
            o = -32'sd1073741824;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

    function automatic logic signed [29:0] sat28(input logic signed [34:0] v);
        logic signed [29:0] o;
        if (v > 35'sd268435456) begin
            o = 30'sd268435456;
        end else if (v < -35'sd268435456) begin
            o = -30'sd268435456;
        end else begin
            o = v[29:0];
        end
        return o;
    endfunction

    function automatic t_cordic prerot(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y);
        t_cordic c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.acc  = 32'h0000_0000;
        if (x[CW-1]) begin
            if (!y[CW-1]) begin
                c.x   = y;
                c.y   = -x;
                c.acc = 32'h4000_0000;
            end else begin
                c.x   = -y;
                c.y   = x;
                c.acc = 32'hC000_0000;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/qte_matrix.sv =====
module qte_matrix (
    input  logic          i_clk,
    input  logic          i_en,
    input  qte_pkg::t_quat i_quat,
    output qte_pkg::t_mat o_mat
);

    localparam logic signed [34:0] ONE = 35'sd268435456;

    logic signed [15:0] w, x, y, z;
    logic signed [31:0] r_yy, r_zz, r_xx, r_xy, r_zw, r_yw, r_xz, r_yz, r_xw;
    logic signed [31:0] r_r00, r_r10, r_r21, r_r22, r_nr12, r_r11;
    logic signed [29:0] r_s;
    qte_pkg::t_mat      r_mat;
    logic signed [63:0] m00, m10;
    logic signed [59:0] mss;

    generate
        if (qte_pkg::COMPONENT_WIDTH > 16) begin : g_wide
            localparam int SH = qte_pkg::COMPONENT_WIDTH - 16;
            assign w = 16'(i_quat.quat_w >>> SH);
            assign x = 16'(i_quat.quat_x >>> SH);
            assign y = 16'(i_quat.quat_y >>> SH);
            assign z = 16'(i_quat.quat_z >>> SH);
        end else begin : g_narrow
            localparam int SH = 16 - qte_pkg::COMPONENT_WIDTH;
            assign w = 16'(i_quat.quat_w) <<< SH;
            assign x = 16'(i_quat.quat_x) <<< SH;
            assign y = 16'(i_quat.quat_y) <<< SH;
            assign z = 16'(i_quat.quat_z) <<< SH;
        end
    endgenerate

    assign m00 = r_r00 * r_r00;
    assign m10 = r_r10 * r_r10;
    assign mss = r_s * r_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yy <= y * y;
            r_zz <= z * z;
            r_xx <= x * x;
            r_xy <= x * y;
            r_zw <= z * w;
            r_yw <= y * w;
            r_xz <= x * z;
            r_yz <= y * z;
            r_xw <= x * w;

            r_r00  <= qte_pkg::sat30(ONE - ((35'(r_yy) + 35'(r_zz)) <<< 1));
            r_r10  <= qte_pkg::sat30((35'(r_xy) + 35'(r_zw)) <<< 1);
            r_r21  <= qte_pkg::sat30((35'(r_yz) + 35'(r_xw)) <<< 1);
            r_r22  <= qte_pkg::sat30(ONE - ((35'(r_xx) + 35'(r_yy)) <<< 1));
            r_nr12 <= qte_pkg::sat30((35'(r_xw) - 35'(r_yz)) <<< 1);
            r_r11  <= qte_pkg::sat30(ONE - ((35'(r_xx) + 35'(r_zz)) <<< 1));
            r_s    <= qte_pkg::sat28((35'(r_yw) - 35'(r_xz)) <<< 1);

            r_mat.r00  <= r_r00;
            r_mat.r10  <= r_r10;
            r_mat.r21  <= r_r21;
            r_mat.r22  <= r_r22;
            r_mat.nr12 <= r_nr12;
            r_mat.r11  <= r_r11;
            r_mat.s    <= r_s;
            r_mat.sq00 <= m00[61:0];
            r_mat.sq10 <= m10[61:0];
            r_mat.ss   <= 58'(mss[56:0]);
        end
    end

    assign o_mat = r_mat;

endmodule

// ===== rtl/qte_sqrt_cell.sv =====
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  qte_pkg::t_sq i_d,
    output qte_pkg::t_sq o_d
);

    localparam logic [qte_pkg::SQRT_W-1:0] BIT = qte_pkg::SQRT_W'(1) << (2 * K);

    logic [qte_pkg::SQRT_W-1:0] t;
    qte_pkg::t_sq n_d, r_d;

    always_comb begin
        t = i_d.r + BIT;
        if (i_d.n >= t) begin
            n_d.n = i_d.n - t;
            n_d.r = (i_d.r >> 1) + BIT;
        end else begin
            n_d.n = i_d.n;
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/qte_cordic_cell.sv =====
module qte_cordic_cell #(
    parameter int I = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  qte_pkg::t_cordic i_d,
    output qte_pkg::t_cordic o_d
);

    logic signed [qte_pkg::CW-1:0] xs, ys;
    qte_pkg::t_cordic n_d, r_d;

    assign xs = i_d.x >>> I;
    assign ys = i_d.y >>> I;

    always_comb begin
        n_d.zero = i_d.zero;
        if (!i_d.y[qte_pkg::CW-1]) begin
            n_d.x   = i_d.x + ys;
            n_d.y   = i_d.y - xs;
            n_d.acc = i_d.acc + qte_pkg::atan_tab(I);
        end else begin
            n_d.x   = i_d.x - ys;
            n_d.y   = i_d.y + xs;
            n_d.acc = i_d.acc - qte_pkg::atan_tab(I);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/quaternion_to_euler_zyx_top.sv =====
// Throughput: one beat per cycle; the 29-cell square root chain and the CORDIC cell
// chains are fully pipelined, and the whole pipe advances whenever the output is free.
// Reset (i_rst_n low, synchronous): pipeline empties, threshold returns to 1.
module quaternion_to_euler_zyx_top #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  qte_pkg::t_quat              i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output qte_pkg::t_euler             o_out_data,
    input  logic                        i_cfg_we,
    input  logic [qte_pkg::THRESH_W-1:0] i_cfg_wdata
);

    localparam int NS = (CORDIC_STAGES > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN
                                                             : CORDIC_STAGES;
    localparam int NQ = qte_pkg::SQRT_CELLS;
    localparam int D  = 6 + NQ + NS;

    logic                         en;
    logic [D-1:0]                 r_vld;
    logic [qte_pkg::THRESH_W-1:0] r_thresh;
    qte_pkg::t_mat                mat;
    qte_pkg::t_sq                 r_sq0;
    qte_pkg::t_side               r_side [0:NQ];
    qte_pkg::t_sq                 sq     [0:NQ];
    qte_pkg::t_cordic             c_roll [0:NS];
    qte_pkg::t_cordic             c_pit  [0:NS];
    qte_pkg::t_cordic             c_yaw  [0:NS];
    logic [NS:0]                  r_sing;
    logic [61:0]                  magsum;
    logic                         sing;
    logic [31:0]                  rnd_roll, rnd_pit, rnd_yaw;
    qte_pkg::t_euler              r_out;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[D-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_thresh <= qte_pkg::THRESH_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[D-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
        end
    end

    qte_matrix u_matrix (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_quat (i_in_data),
        .o_mat  (mat)
    );

    assign magsum = mat.sq00 + mat.sq10;
    assign sing   = 34'(magsum >> 28) < 34'(r_thresh);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq0.n <= qte_pkg::SQRT_W'(58'd1 << 56) - mat.ss;
            r_sq0.r <= '0;
            r_side[0].sing   <= sing;
            r_side[0].s      <= mat.s;
            r_side[0].yaw_x  <= qte_pkg::CW'(mat.r00);
            r_side[0].yaw_y  <= qte_pkg::CW'(mat.r10);
            r_side[0].roll_x <= sing ? qte_pkg::CW'(mat.r11)  : qte_pkg::CW'(mat.r22);
            r_side[0].roll_y <= sing ? qte_pkg::CW'(mat.nr12) : qte_pkg::CW'(mat.r21);
            for (int k = 1; k <= NQ; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign sq[0] = r_sq0;

    genvar g;
    generate
        for (g = 0; g < NQ; g++) begin : g_sqrt
            qte_sqrt_cell #(.K(NQ - 1 - g)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (sq[g]),
                .o_d   (sq[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_roll[0] <= qte_pkg::prerot(r_side[NQ].roll_x, r_side[NQ].roll_y);
            c_yaw[0]  <= qte_pkg::prerot(r_side[NQ].yaw_x, r_side[NQ].yaw_y);
            c_pit[0]  <= qte_pkg::prerot(qte_pkg::CW'(sq[NQ].r[29:0]),
                                         qte_pkg::CW'(r_side[NQ].s));
            r_sing    <= {r_sing[NS-1:0], r_side[NQ].sing};
        end
    end

    generate
        for (g = 0; g < NS; g++) begin : g_cordic
            qte_cordic_cell #(.I(g)) u_roll (
                .i_clk (i_clk), .i_en (en), .i_d (c_roll[g]), .o_d (c_roll[g+1])
            );
            qte_cordic_cell #(.I(g)) u_pitch (
                .i_clk (i_clk), .i_en (en), .i_d (c_pit[g]), .o_d (c_pit[g+1])
            );
            qte_cordic_cell #(.I(g)) u_yaw (
                .i_clk (i_clk), .i_en (en), .i_d (c_yaw[g]), .o_d (c_yaw[g+1])
            );
        end
    endgenerate

    assign rnd_roll = c_roll[NS].acc + 32'h0000_8000;
    assign rnd_pit  = c_pit[NS].acc  + 32'h0000_8000;
    assign rnd_yaw  = c_yaw[NS].acc  + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.roll_angle      <= c_roll[NS].zero ? 16'sd0 : rnd_roll[31:16];
            r_out.pitch_angle     <= c_pit[NS].zero  ? 16'sd0 : rnd_pit[31:16];
            r_out.yaw_angle       <= (c_yaw[NS].zero || r_sing[NS]) ? 16'sd0
                                                                    : rnd_yaw[31:16];
            r_out.gimbal_singular <= r_sing[NS];
        end
    end

endmodule

// ===== rtl/qte_checker.sv =====
`include "assert_macros.svh"

module qte_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input qte_pkg::t_quat               i_in_data,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input qte_pkg::t_euler              o_out_data,
    input logic                         i_cfg_we,
    input logic [qte_pkg::THRESH_W-1:0] i_cfg_wdata
);

    `QTE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output beat dropped or changed while stalled")
    `QTE_ASSERT_IMP(a_sing_yaw, o_out_valid && o_out_data.gimbal_singular, o_out_data.yaw_angle == 16'sd0, "yaw not zero on singular beat")
    `QTE_ASSERT_IMP(a_ready, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without output backpressure")
    `QTE_ASSERT_RST(a_rst, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

bind quaternion_to_euler_zyx_top qte_checker u_qte_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 35 + ((qte_pkg::CORDIC_STAGES > 24) ? 24
                                                                     : qte_pkg::CORDIC_STAGES);
    localparam int N_RANDOM    = 625;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [qte_pkg::THRESH_W-1:0] t_thresh;

    class euler_scoreboard;
        qte_pkg::t_euler pending[$];
        t_thresh thresh;
        int mismatches;
        int matched;
        int singular_seen;

        function new();
            thresh = qte_pkg::THRESH_RST;
            mismatches = 0;
            matched = 0;
            singular_seen = 0;
        endfunction

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function longint int_sqrt(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function logic [31:0] vector_angle(longint yv, longint xv);
            logic [31:0] acc;
            longint t, xs, ys;
            int stages;
            acc = '0;
            stages = (qte_pkg::CORDIC_STAGES > 24) ? 24 : qte_pkg::CORDIC_STAGES;
            if (xv == 0 && yv == 0) return '0;
            if (xv < 0) begin
                if (yv >= 0) begin
                    t = xv; xv = yv; yv = -t; acc = 32'h4000_0000;
                end else begin
                    t = xv; xv = -yv; yv = t; acc = 32'hC000_0000;
                end
            end
            for (int i = 0; i < stages; i++) begin
                xs = floor_shift(xv, i);
                ys = floor_shift(yv, i);
                if (yv >= 0) begin
                    xv = xv + ys; yv = yv - xs; acc += qte_pkg::atan_tab(i);
                end else begin
                    xv = xv - ys; yv = yv + xs; acc -= qte_pkg::atan_tab(i);
                end
            end
            return acc;
        endfunction

        function logic [15:0] to_bam16(logic [31:0] acc);
            logic [31:0] r;
            r = acc + 32'h8000;
            return r[31:16];
        endfunction

        function longint comp16(logic signed [qte_pkg::COMPONENT_WIDTH-1:0] raw);
            longint v;
            v = raw;
            if (qte_pkg::COMPONENT_WIDTH > 16) return v >>> (qte_pkg::COMPONENT_WIDTH - 16);
            return v * (64'sd1 << (16 - qte_pkg::COMPONENT_WIDTH));
        endfunction

        function void note_quat(qte_pkg::t_quat q);
            longint w, x, y, z, r00, r10, s, c, a, b;
            longint unsigned mag;
            logic sing;
            qte_pkg::t_euler e;
            w = comp16(q.quat_w); x = comp16(q.quat_x);
            y = comp16(q.quat_y); z = comp16(q.quat_z);
            r00 = clamp((64'sd1 << 28) - 2 * (y * y + z * z), 64'sd1 << 30);
            r10 = clamp(2 * (x * y + z * w), 64'sd1 << 30);
            s = clamp(2 * (y * w - x * z), 64'sd1 << 28);
            mag = (longint'(r00 * r00) + longint'(r10 * r10)) >> 28;
            c = int_sqrt((64'd1 << 56) - longint'(s * s));
            sing = mag < longint'(thresh);
            if (!sing) begin
                a = clamp(2 * (y * z + x * w), 64'sd1 << 30);
                b = clamp((64'sd1 << 28) - 2 * (x * x + y * y), 64'sd1 << 30);
                e.roll_angle = to_bam16(vector_angle(a, b));
                e.yaw_angle = to_bam16(vector_angle(r10, r00));
            end else begin
                a = clamp(2 * (x * w - y * z), 64'sd1 << 30);
                b = clamp((64'sd1 << 28) - 2 * (x * x + z * z), 64'sd1 << 30);
                e.roll_angle = to_bam16(vector_angle(a, b));
                e.yaw_angle = '0;
            end
            e.pitch_angle = to_bam16(vector_angle(s, c));
            e.gimbal_singular = sing;
            pending = {pending, e};
        endfunction

        function void check_euler(qte_pkg::t_euler got);
            qte_pkg::t_euler want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.gimbal_singular) singular_seen++;
            if (got.roll_angle !== want.roll_angle || got.pitch_angle !== want.pitch_angle ||
                got.yaw_angle !== want.yaw_angle ||
                got.gimbal_singular !== want.gimbal_singular) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d sing %0b/%0b",
                             want.roll_angle, got.roll_angle, want.pitch_angle,
                             got.pitch_angle, want.yaw_angle, got.yaw_angle,
                             want.gimbal_singular, got.gimbal_singular);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready, i_cfg_we;
    qte_pkg::t_quat i_in_data;
    qte_pkg::t_euler o_out_data;
    logic [qte_pkg::THRESH_W-1:0] i_cfg_wdata;

    euler_scoreboard board;
    int cycles;
    bit idle_off;
    bit hold_off;

    quaternion_to_euler_zyx_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // input beats noted and output beats checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) board.note_quat(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) board.check_euler(o_out_data);
    end

    // receiver: random stalls, one long hold-off
    initial begin
        i_out_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) i_out_ready <= 0;
            else if (idle_off) i_out_ready <= 1;
            else i_out_ready <= ($urandom_range(99) >= 33);
        end
    end

    // valid stays high after the beat so the next one can follow directly
    task automatic send_quat(input qte_pkg::t_quat q);
        if (!idle_off) begin
            while ($urandom_range(99) < 33) begin
                i_in_valid <= 0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1;
        i_in_data <= q;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_and_write(input t_thresh val);
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= val;
        board.thresh = val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic qte_pkg::t_quat mk(int w, int x, int y, int z);
        qte_pkg::t_quat q;
        q.quat_w = qte_pkg::COMPONENT_WIDTH'(w);
        q.quat_x = qte_pkg::COMPONENT_WIDTH'(x);
        q.quat_y = qte_pkg::COMPONENT_WIDTH'(y);
        q.quat_z = qte_pkg::COMPONENT_WIDTH'(z);
        return q;
    endfunction

    function automatic int rnd_comp();
        int v;
        v = $urandom_range(32767);
        if ($urandom_range(1)) v = -v;
        if ($urandom_range(9) == 0) v = $signed(16'($urandom));
        return v;
    endfunction

    // roughly unit quaternion from random direction
    function automatic qte_pkg::t_quat rnd_unit();
        real a, b, c, d, n;
        a = $signed($urandom) / 2147483648.0;
        b = $signed($urandom) / 2147483648.0;
        c = $signed($urandom) / 2147483648.0;
        d = $signed($urandom) / 2147483648.0;
        if ($urandom_range(4) == 0) begin
            // near gimbal lock: y*w - x*z close to +-0.5
            a = 1.0; c = ($urandom_range(1)) ? 1.0 : -1.0;
            b = b * 0.02; d = d * 0.02;
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1e-3) n = 1.0;
        return mk($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                  $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
    endfunction

    task automatic random_phase(input int n);
        qte_pkg::t_quat q;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) q = rnd_unit();
            else q = mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
            send_quat(q);
        end
    endtask

    initial begin
        t_thresh settings[4];
        board = new();
        cycles = 0;
        idle_off = 0;
        hold_off = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_quat(mk(16384, 0, 0, 0));
        send_quat(mk(-16384, 0, 0, 0));
        send_quat(mk(0, 16384, 0, 0));
        send_quat(mk(0, 0, 16384, 0));
        send_quat(mk(0, 0, 0, 16384));
        send_quat(mk(0, 0, 0, -16384));
        send_quat(mk(11585, 0, 11585, 0));
        send_quat(mk(11585, 0, -11585, 0));
        send_quat(mk(11585, 11585, 0, 0));
        send_quat(mk(0, 0, 0, 0));
        send_quat(mk(32767, 32767, 32767, 32767));
        send_quat(mk(-32768, -32768, -32768, -32768));
        send_quat(mk(-32768, 32767, -32768, 32767));
        send_quat(mk(8192, 8192, 8192, 8192));
        send_quat(mk(8192, -8192, 8192, 8192));
        send_quat(mk(0, 11585, 0, 11585));

        settings[0] = 29'd0;
        settings[1] = 29'h1FFF_FFFF;
        settings[2] = 29'd268435456;
        settings[3] = 29'd2684354;
        drain_and_write(settings[0]);
        send_quat(mk(11585, 0, 11585, 0));
        send_quat(mk(16384, 0, 0, 0));
        drain_and_write(settings[1]);
        send_quat(mk(16384, 0, 0, 0));
        send_quat(mk(8192, 8192, 8192, 8192));
        drain_and_write(qte_pkg::THRESH_RST);

        random_phase(150);

        // back-pressure: receiver stalls while inputs keep coming
        fork
            begin
                hold_off = 1;
                repeat (3 * LATENCY) @(negedge i_clk);
                hold_off = 0;
            end
            begin
                idle_off = 1;
                random_phase(100);
                idle_off = 0;
            end
        join

        for (int k = 2; k < 4; k++) begin
            drain_and_write(settings[k]);
            random_phase(100);
        end
        drain_and_write(qte_pkg::THRESH_RST);
        random_phase(N_RANDOM - 450);

        i_in_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("checked %0d euler results (%0d singular) over %0d threshold settings",
                 board.matched, board.singular_seen, 7);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
